FILE: rtl/nab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nab_pkg;

  // line store geometry
  localparam int unsigned MaxLineWidth = 512;
  localparam int unsigned ColW         = $clog2(MaxLineWidth);
  localparam int unsigned RowW         = 10;
  localparam int unsigned CfgW         = 10;
  localparam int unsigned PixW         = 8;
  localparam int unsigned OutPixW      = 7;
  localparam int unsigned SumW         = 11;
  localparam int unsigned CfgIdxW      = 1;

  // register reset values and legal ranges
  localparam logic [CfgW-1:0] LineWidthRst   = CfgW'(320);
  localparam logic [CfgW-1:0] FrameHeightRst = CfgW'(200);
  localparam logic [CfgW-1:0] MinDim         = CfgW'(3);
  localparam logic [CfgW-1:0] MaxWidth       = CfgW'(MaxLineWidth);
  localparam logic [CfgW-1:0] MaxHeight      = CfgW'(1023);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  // one line store entry: both earlier lines at the same column
  typedef struct packed {
    logic [PixW-1:0] middle;
    logic [PixW-1:0] upper;
  } line_entry_t;

  // write side of the line store
  typedef struct packed {
    logic              en;
    logic [ColW-1:0]   addr;
    line_entry_t       data;
  } line_wr_t;

  function automatic logic [CfgW-1:0] used_width(input logic [CfgW-1:0] w);
    logic [CfgW-1:0] r;
    r = w;
    if (r < MinDim) r = MinDim;
    if (r > MaxWidth) r = MaxWidth;
    return r;
  endfunction

  function automatic logic [CfgW-1:0] used_height(input logic [CfgW-1:0] h);
    logic [CfgW-1:0] r;
    r = h;
    if (r < MinDim) r = MinDim;
    if (r > MaxHeight) r = MaxHeight;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nab_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module nab_line_buf (
  input  wire logic                      clk_i,
  input  wire logic                      rd_en_i,
  input  wire logic [nab_pkg::ColW-1:0]  rd_addr_i,
  input  wire nab_pkg::line_wr_t         wr_i,
  output nab_pkg::line_entry_t           rd_data_o
);
  import nab_pkg::*;

  line_entry_t mem_q [MaxLineWidth];
  line_entry_t rdata_q;
  line_entry_t fwd_data_q;
  logic        fwd_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // read port, registered, held until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      fwd_q      <= wr_i.en && (wr_i.addr == rd_addr_i);
      fwd_data_q <= wr_i.data;
    end
  end

  // same-entry write in the read cycle wins over the old contents
  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

`default_nettype wire

FILE: rtl/neighbour_average_blur.sv
`timescale 1ns / 1ps
`default_nettype none

// Eight-neighbour fading blur on a raster pixel stream.
// Slave channel: one 8-bit pixel per transfer, tuser marks the first pixel
// of a frame and resets the position to column 0, row 0.
// Master channel: one result per interior pixel, the sum of the eight
// neighbours shifted right by four, tagged with the centre column and row;
// tlast marks the last interior result of the frame. Border positions give
// no result. The window centre trails the incoming pixel by one line and
// one column.
// Config channel: index 0 = line_width, index 1 = frame_height; write only
// while the stream is idle. cfg_ready_o is always high.
// A result passes through the store stage and then the output register after
// the input transfer that completes its window. Throughput: one pixel per clock
// unless stalled, set by the line store's single read and single write port.
// Reset: position counters and window clear, registers return to 320 x 200,
// the line store is not cleared (entries are written before being read).
// When the receiver stalls, the result holds in the output register and one
// more pixel can be taken into the store stage before s_axis_tready_o drops.
module neighbour_average_blur (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // pixel_in[7:0]
  input  wire logic [7:0]                  s_axis_tdata_i,
  // frame_start
  input  wire logic                        s_axis_tuser_i,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // pixel_out[6:0], out_col[15:7], out_row[25:16], zero[31:26]
  output logic [31:0]                      m_axis_tdata_o,
  // frame_last
  output logic                             m_axis_tlast_o,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [nab_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [nab_pkg::CfgW-1:0]    cfg_data_i
);
  import nab_pkg::*;

  // configuration registers
  logic [CfgW-1:0] line_width_q, frame_height_q;
  logic [CfgW-1:0] w, h;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LineWidthRst;
      frame_height_q <= FrameHeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LINE_WIDTH:   line_width_q   <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign w = used_width(line_width_q);
  assign h = used_height(frame_height_q);

  // handshake
  logic s_acc, out_free, s1_adv;
  logic s1_valid_q, s1_res_q, s1_last_q;
  logic out_valid_q;

  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && (!s1_res_q || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  // position of the incoming pixel and of the next one
  logic [ColW-1:0] col_q, col_d, cur_col;
  logic [RowW-1:0] row_q, row_d;
  logic [CfgW-1:0] c0, c1, c2;
  logic [RowW-1:0] r0, r1, r2;
  logic            has_res, is_last;

  always_comb begin
    c0 = s_axis_tuser_i ? '0 : CfgW'(col_q);
    r0 = s_axis_tuser_i ? '0 : row_q;
    c1 = c0;
    r1 = r0;
    if (c0 >= w) begin
      c1 = '0;
      r1 = r0 + RowW'(1);
    end
    if (r1 >= RowW'(h)) r1 = '0;
    cur_col = c1[ColW-1:0];

    c2 = c1 + CfgW'(1);
    r2 = r1;
    if (c2 >= w) begin
      c2 = '0;
      r2 = r1 + RowW'(1);
    end
    if (r2 >= RowW'(h)) r2 = '0;
    col_d = c2[ColW-1:0];
    row_d = r2;

    has_res = (c1 >= CfgW'(2)) && (r1 >= RowW'(2));
    is_last = (c1 == w - CfgW'(1)) && (r1 == RowW'(h) - RowW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (s_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // store stage: line store data arrives here
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;
  logic [PixW-1:0] s1_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_res_q   <= 1'b0;
      s1_last_q  <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_acc;
      s1_res_q   <= has_res;
      s1_last_q  <= is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_col_q <= cur_col;
      s1_row_q <= r1;
      s1_pix_q <= s_axis_tdata_i;
    end
  end

  // line store, read at accept, written back as the item leaves the stage
  line_entry_t rd_data;
  line_wr_t    wr;

  assign wr.en          = s1_adv;
  assign wr.addr        = s1_col_q;
  assign wr.data.middle = s1_pix_q;
  assign wr.data.upper  = rd_data.middle;

  nab_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (s_acc),
    .rd_addr_i (cur_col),
    .wr_i      (wr),
    .rd_data_o (rd_data)
  );

  // window columns: c-1 in win1_q, c-2 in win2_q
  logic [3*PixW-1:0] win1_q, win2_q, cur_colm;
  logic [SumW-1:0]   sum;

  assign cur_colm = {s1_pix_q, rd_data.middle, rd_data.upper};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q <= '0;
      win2_q <= '0;
    end else if (s1_adv) begin
      win1_q <= cur_colm;
      win2_q <= win1_q;
    end
  end

  // eight-neighbour sum, centre excluded
  always_comb begin
    sum = SumW'(win2_q[7:0]) + SumW'(win2_q[15:8]) + SumW'(win2_q[23:16])
        + SumW'(win1_q[7:0]) + SumW'(win1_q[23:16])
        + SumW'(cur_colm[7:0]) + SumW'(cur_colm[15:8]) + SumW'(cur_colm[23:16]);
  end

  // output register
  logic [OutPixW-1:0] out_pix_q;
  logic [ColW-1:0]    out_col_q;
  logic [RowW-1:0]    out_row_q;
  logic               out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_res_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_res_q) begin
      out_pix_q  <= sum[SumW-1:4];
      out_col_q  <= s1_col_q - ColW'(1);
      out_row_q  <= s1_row_q - RowW'(1);
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {6'b0, out_row_q, out_col_q, out_pix_q};

endmodule

`default_nettype wire

FILE: rtl/nab_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module nab_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

  // no result appears without a recent input transfer
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o && !$past(s_acc) |=> !m_axis_tvalid_o)
    else $error("result without input transfer");

  // results have a non-zero column and row and a zero top field
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[15:7] != 9'd0) && (m_axis_tdata_o[25:16] != 10'd0)
      && (m_axis_tdata_o[31:26] == 6'd0))
    else $error("border or malformed result");

endmodule

bind neighbour_average_blur nab_checker u_nab_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire
